### design/roll_sweep_plot_buffer_core_defines.svh
// ----------------------------------------------------------------------------
// roll_sweep_plot_buffer_core_defines
// assertion macros shared by the plot buffer modules
// ----------------------------------------------------------------------------
`ifndef ROLL_SWEEP_PLOT_BUFFER_CORE_DEFINES_SVH
`define ROLL_SWEEP_PLOT_BUFFER_CORE_DEFINES_SVH

`ifndef ASSERT_OFF
// checked on every edge outside reset
`define RSPB_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("%m: assertion failed");
// checked on every edge, reset included
`define RSPB_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("%m: assertion failed");
`else
`define RSPB_ASSERT(lbl, prop)
`define RSPB_ASSERT_ALWAYS(lbl, prop)
`endif

`endif

### design/rspb_pkg.sv
// ----------------------------------------------------------------------------
// rspb_pkg
// shared constants, codes and the command type of the plot buffer
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package rspb_pkg;

  localparam int MAX_FRAME   = 4096;
  localparam int SAMPLE_BITS = 16;
  localparam int ADDR_BITS   = $clog2(MAX_FRAME);
  localparam int COUNT_BITS  = $clog2(MAX_FRAME + 1);
  localparam int CLEN_BITS   = 16;
  localparam int MODE_BITS   = 2;
  localparam int Q_DEPTH     = 4;
  localparam int Q_PTR_BITS  = $clog2(Q_DEPTH);

  // input item modes
  localparam logic [MODE_BITS-1:0] MODE_PUSH  = 2'd0;
  localparam logic [MODE_BITS-1:0] MODE_READ  = 2'd1;
  localparam logic [MODE_BITS-1:0] MODE_CLEAR = 2'd2;

  // result kinds
  localparam logic KIND_PASS = 1'b0;
  localparam logic KIND_READ = 1'b1;

  // register indexes
  localparam logic REG_PLOT_SIZE    = 1'b0;
  localparam logic REG_ROLLING_MODE = 1'b1;

  typedef enum logic [1:0] {
    OP_WRITE,
    OP_READ,
    OP_PASS
  } op_t;

  typedef struct packed {
    op_t                    op;
    logic [ADDR_BITS-1:0]   addr;
    logic [SAMPLE_BITS-1:0] data;
    logic [COUNT_BITS-1:0]  count;
    logic                   last;
    logic                   in_range;
  } cmd_t;

endpackage

`default_nettype wire

### design/rspb_ram.sv
// ----------------------------------------------------------------------------
// rspb_ram
// generic simple dual-port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rspb_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

### design/rspb_front.sv
// ----------------------------------------------------------------------------
// rspb_front
// accepts items and register writes, tracks fill and pointers, issues commands
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "roll_sweep_plot_buffer_core_defines.svh"

module rspb_front import rspb_pkg::*; (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   psel,
  input  wire logic                   penable,
  input  wire logic                   pwrite,
  input  wire logic [2:0]             paddr,
  input  wire logic [31:0]            pwdata,
  output logic      [31:0]            prdata,
  input  wire logic                   in_valid,
  output logic                        in_ready,
  input  wire logic [MODE_BITS-1:0]   mode,
  input  wire logic [SAMPLE_BITS-1:0] sample,
  input  wire logic [CLEN_BITS-1:0]   chunk_length,
  input  wire logic                   chunk_end,
  input  wire logic [ADDR_BITS-1:0]   read_index,
  input  wire logic                   q_full,
  output logic                        q_push,
  output cmd_t                        q_cmd
);

  localparam logic [COUNT_BITS-1:0] FRAME_CAP = COUNT_BITS'(MAX_FRAME);
  localparam logic [CLEN_BITS-1:0]  POS_MAX   = '1;

  logic [COUNT_BITS-1:0] plot_size;
  logic                  rolling_mode;
  logic [COUNT_BITS-1:0] fill_count, fill_count_next;
  logic [ADDR_BITS-1:0]  write_pointer, write_pointer_next;
  logic                  wrapped, wrapped_next;
  logic [CLEN_BITS-1:0]  chunk_position, chunk_position_next;

  logic [COUNT_BITS-1:0] ps;
  logic                  accept;
  logic                  cfg_write;
  logic [COUNT_BITS-1:0] wp_base;
  logic [COUNT_BITS-1:0] wp_inc;
  logic [COUNT_BITS-1:0] fill_eff;
  logic [COUNT_BITS-1:0] rd_sum;
  logic [COUNT_BITS-1:0] rd_addr;
  logic                  rd_ok;

  assign ps        = (plot_size > FRAME_CAP) ? FRAME_CAP : plot_size;
  assign in_ready  = !q_full;
  assign accept    = in_valid && in_ready;
  assign cfg_write = psel && penable && pwrite;
  assign prdata    = (paddr[2] == REG_ROLLING_MODE) ? {31'd0, rolling_mode}
                                                    : {{(32-COUNT_BITS){1'b0}}, plot_size};

  // roll mode write slot
  assign wp_base = ({1'b0, write_pointer} >= ps) ? '0 : {1'b0, write_pointer};
  assign wp_inc  = wp_base + COUNT_BITS'(1);

  // sweep mode restarts on a new chunk once full
  assign fill_eff = (chunk_position == '0 && fill_count >= ps) ? '0 : fill_count;

  // read address, oldest first
  assign rd_ok   = {1'b0, read_index} < fill_count;
  assign rd_sum  = {1'b0, write_pointer} + {1'b0, read_index};
  assign rd_addr = (rolling_mode && wrapped && ps != '0)
                   ? ((rd_sum >= ps) ? rd_sum - ps : rd_sum)
                   : {1'b0, read_index};

  always_comb begin
    fill_count_next     = fill_count;
    write_pointer_next  = write_pointer;
    wrapped_next        = wrapped;
    chunk_position_next = chunk_position;
    q_push              = 1'b0;
    q_cmd.op            = OP_WRITE;
    q_cmd.addr          = '0;
    q_cmd.data          = sample;
    q_cmd.count         = fill_count;
    q_cmd.last          = 1'b0;
    q_cmd.in_range      = 1'b0;
    if (accept) begin
      unique case (mode)
        MODE_PUSH: begin
          if (ps != '0) begin
            if (chunk_length >= CLEN_BITS'(ps)) begin
              if (chunk_position < CLEN_BITS'(ps)) begin
                q_push     = 1'b1;
                q_cmd.op   = OP_PASS;
                q_cmd.last = (chunk_position == CLEN_BITS'(ps - COUNT_BITS'(1)));
              end
            end else if (!rolling_mode) begin
              if (fill_eff != fill_count) begin
                write_pointer_next = '0;
                wrapped_next       = 1'b0;
              end
              fill_count_next = fill_eff;
              if (fill_eff < ps) begin
                q_push          = 1'b1;
                q_cmd.op        = OP_WRITE;
                q_cmd.addr      = fill_eff[ADDR_BITS-1:0];
                fill_count_next = fill_eff + COUNT_BITS'(1);
              end
            end else begin
              q_push     = 1'b1;
              q_cmd.op   = OP_WRITE;
              q_cmd.addr = wp_base[ADDR_BITS-1:0];
              if (wp_inc >= ps) begin
                write_pointer_next = '0;
                wrapped_next       = 1'b1;
                fill_count_next    = ps;
              end else begin
                write_pointer_next = wp_inc[ADDR_BITS-1:0];
                fill_count_next    = wrapped ? ps : wp_inc;
              end
            end
          end
          if (chunk_end) begin
            chunk_position_next = '0;
          end else if (chunk_position < POS_MAX) begin
            chunk_position_next = chunk_position + CLEN_BITS'(1);
          end
        end
        MODE_READ: begin
          q_push         = 1'b1;
          q_cmd.op       = OP_READ;
          q_cmd.addr     = rd_addr[ADDR_BITS-1:0];
          q_cmd.last     = rd_ok && ({1'b0, read_index} == fill_count - COUNT_BITS'(1));
          q_cmd.in_range = rd_ok;
        end
        MODE_CLEAR: begin
          fill_count_next    = '0;
          write_pointer_next = '0;
          wrapped_next       = 1'b0;
        end
        default: begin
        end
      endcase
    end
    if (cfg_write) begin
      fill_count_next    = '0;
      write_pointer_next = '0;
      wrapped_next       = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      plot_size      <= '0;
      rolling_mode   <= 1'b0;
      fill_count     <= '0;
      write_pointer  <= '0;
      wrapped        <= 1'b0;
      chunk_position <= '0;
    end else begin
      if (cfg_write) begin
        if (paddr[2] == REG_PLOT_SIZE) begin
          plot_size <= pwdata[COUNT_BITS-1:0];
        end else begin
          rolling_mode <= pwdata[0];
        end
      end
      fill_count     <= fill_count_next;
      write_pointer  <= write_pointer_next;
      wrapped        <= wrapped_next;
      chunk_position <= chunk_position_next;
    end
  end

  `RSPB_ASSERT(a_fill_bound, fill_count <= ps)
  `RSPB_ASSERT(a_wrap_full, (rolling_mode && wrapped) |-> (fill_count == ps))
  `RSPB_ASSERT(a_wp_bound, (rolling_mode && ps != '0) |-> ({1'b0, write_pointer} < ps))

endmodule

`default_nettype wire

### design/rspb_queue.sv
// ----------------------------------------------------------------------------
// rspb_queue
// short command queue between the front and the back
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "roll_sweep_plot_buffer_core_defines.svh"

module rspb_queue import rspb_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  wire cmd_t push_cmd,
  output logic      full,
  input  wire logic pop,
  output logic      empty,
  output cmd_t      head
);

  cmd_t                  entries [Q_DEPTH];
  logic [Q_PTR_BITS-1:0] wptr;
  logic [Q_PTR_BITS-1:0] rptr;
  logic [Q_PTR_BITS:0]   count;

  assign full  = (count == (Q_PTR_BITS+1)'(Q_DEPTH));
  assign empty = (count == '0);
  assign head  = entries[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= wptr + Q_PTR_BITS'(1);
      end
      if (pop) begin
        rptr <= rptr + Q_PTR_BITS'(1);
      end
      if (push && !pop) begin
        count <= count + (Q_PTR_BITS+1)'(1);
      end else if (pop && !push) begin
        count <= count - (Q_PTR_BITS+1)'(1);
      end
    end
  end

  `RSPB_ASSERT(a_no_overflow, push |-> !full)
  `RSPB_ASSERT(a_no_underflow, pop |-> !empty)
  `RSPB_ASSERT(a_count_bound, count <= (Q_PTR_BITS+1)'(Q_DEPTH))
  `RSPB_ASSERT_ALWAYS(a_reset_empty, rst |=> empty)

endmodule

`default_nettype wire

### design/rspb_back.sv
// ----------------------------------------------------------------------------
// rspb_back
// carries out store writes and reads and drives the result register
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rspb_back import rspb_pkg::*; (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    q_empty,
  input  wire cmd_t                    q_head,
  output logic                         q_pop,
  output logic                         out_valid,
  input  wire logic                    out_ready,
  output logic                         out_kind,
  output logic      [SAMPLE_BITS-1:0]  out_value,
  output logic      [COUNT_BITS-1:0]   out_count,
  output logic                         out_last,
  output logic                         out_in_range
);

  cmd_t                   s1_cmd;
  logic                   s1_valid;
  logic                   s1_adv;
  logic                   s1_free;
  logic                   is_write;
  logic                   ram_we;
  logic                   ram_re;
  logic [SAMPLE_BITS-1:0] ram_rdata;

  assign s1_adv   = s1_valid && (!out_valid || out_ready);
  assign s1_free  = !s1_valid || s1_adv;
  assign is_write = (q_head.op == OP_WRITE);
  assign q_pop    = !q_empty && (is_write || s1_free);
  assign ram_we   = q_pop && is_write;
  assign ram_re   = q_pop && !is_write;

  rspb_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (MAX_FRAME)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (q_head.addr),
    .wdata (q_head.data),
    .re    (ram_re),
    .raddr (q_head.addr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (ram_re) begin
        s1_valid <= 1'b1;
      end else if (s1_adv) begin
        s1_valid <= 1'b0;
      end
      if (s1_adv) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
    if (ram_re) begin
      s1_cmd <= q_head;
    end
    if (s1_adv) begin
      out_count    <= s1_cmd.count;
      out_last     <= s1_cmd.last;
      out_in_range <= s1_cmd.in_range;
      if (s1_cmd.op == OP_READ) begin
        out_kind  <= KIND_READ;
        out_value <= s1_cmd.in_range ? ram_rdata : '0;
      end else begin
        out_kind  <= KIND_PASS;
        out_value <= s1_cmd.data;
      end
    end
  end

endmodule

`default_nettype wire

### design/roll_sweep_plot_buffer_core.sv
// ----------------------------------------------------------------------------
// roll_sweep_plot_buffer_core
// roll/sweep plot buffer for a scope display
// ----------------------------------------------------------------------------
// Takes one item per clock on the input stream while the command queue has
// room: push a sample, read frame element read_index (0 is oldest) or clear
// the frame. Each item is decoded in the front in its accept cycle; store
// writes, reads and passthrough samples then go through a four-entry command
// queue to the back, which owns the 4096 x 16 sample store (one write and one
// registered read port) and the result register; each result passes through
// the queue, the store read stage and the result register. The store needs no
// clearing pass: a fill count marks the valid entries. Writing plot_size
// (address 0) or rolling_mode (address 4) empties the frame and must only be
// done while the block is idle; the block itself does not enforce this.
`timescale 1ns / 1ps
`default_nettype none

module roll_sweep_plot_buffer_core import rspb_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // sample[15:0], chunk_length[31:16], read_index[43:32], zero[47:44]
  input  wire logic [47:0] s_axis_tdata,
  // mode[1:0]
  input  wire logic [1:0]  s_axis_tuser,
  // chunk_end
  input  wire logic        s_axis_tlast,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // value[15:0], frame_count[28:16], in_range[29], zero[31:30]
  output logic      [31:0] m_axis_tdata,
  // kind
  output logic      [0:0]  m_axis_tuser,
  // frame_last
  output logic             m_axis_tlast
);

  logic                   q_full;
  logic                   q_empty;
  logic                   q_push;
  logic                   q_pop;
  cmd_t                   q_cmd;
  cmd_t                   q_head;
  logic                   out_kind;
  logic [SAMPLE_BITS-1:0] out_value;
  logic [COUNT_BITS-1:0]  out_count;
  logic                   out_in_range;

  assign pready = 1'b1;

  rspb_front u_front (
    .clk          (clk),
    .rst          (rst),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .in_valid     (s_axis_tvalid),
    .in_ready     (s_axis_tready),
    .mode         (s_axis_tuser),
    .sample       (s_axis_tdata[15:0]),
    .chunk_length (s_axis_tdata[31:16]),
    .chunk_end    (s_axis_tlast),
    .read_index   (s_axis_tdata[43:32]),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_cmd        (q_cmd)
  );

  rspb_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_cmd (q_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .empty    (q_empty),
    .head     (q_head)
  );

  rspb_back u_back (
    .clk          (clk),
    .rst          (rst),
    .q_empty      (q_empty),
    .q_head       (q_head),
    .q_pop        (q_pop),
    .out_valid    (m_axis_tvalid),
    .out_ready    (m_axis_tready),
    .out_kind     (out_kind),
    .out_value    (out_value),
    .out_count    (out_count),
    .out_last     (m_axis_tlast),
    .out_in_range (out_in_range)
  );

  assign m_axis_tdata = {2'b00, out_in_range, out_count, out_value};
  assign m_axis_tuser = out_kind;

endmodule

`default_nettype wire
